### rtl/hsls_pkg.sv
// Shared types, codes and reset constants for the scanline list sequencer.
`timescale 1ns / 1ps
`default_nettype none

package hsls_pkg;

    // Default build parameters
    localparam int LINE_BITS_DEF  = 12;
    localparam int ACR_PERIOD_DEF = 4;

    // Fixed field widths of the ports
    localparam int LINE_NUM_W = 12;
    localparam int VIS_W      = 11;
    localparam int FRAME_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DVI_ONLY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_PORCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LINES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_PORCH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LINES = 3'd4;

    // Register reset values
    localparam logic       RST_DVI_ONLY     = 1'b0;
    localparam logic [7:0] RST_FRONT_PORCH  = 8'd10;
    localparam logic [7:0] RST_SYNC_LINES   = 8'd2;
    localparam logic [7:0] RST_BACK_PORCH   = 8'd33;
    localparam logic [10:0] RST_ACTIVE_LINES = 11'd480;

    // Scanline counter start value after reset
    localparam int SCAN_RST = 2;

    // Command list codes
    typedef enum logic [3:0] {
        LC_DVI_BLANK    = 4'd0,
        LC_DVI_VSYNC    = 4'd1,
        LC_DVI_ACTIVE   = 4'd2,
        LC_ACR_VSYNC    = 4'd3,
        LC_INFO_VSYNC   = 4'd4,
        LC_ACTIVE_AUDIO = 4'd5,
        LC_ACTIVE_NULL  = 4'd6,
        LC_PIXELS       = 4'd7,
        LC_ACR_BLANK    = 4'd8,
        LC_AVI          = 4'd9,
        LC_BLANK_AUDIO  = 4'd10,
        LC_BLANK_NULL   = 4'd11
    } t_list_code;

    // Vertical timing registers
    typedef struct packed {
        logic        dvi_only;
        logic [7:0]  vert_front_porch;
        logic [7:0]  vert_sync_lines;
        logic [7:0]  vert_back_porch;
        logic [10:0] vert_active_lines;
    } t_timing;

    // Per-event decision from the line decoder
    typedef struct packed {
        t_list_code       list_code;
        logic             build_buffer;
        logic [VIS_W-1:0] visible_line;
        logic             pixel_request;
        logic             frame_start;
        logic             audio_taken;
        logic             scheduler_tick;
    } t_decision;

endpackage : hsls_pkg

`default_nettype wire

### rtl/hsls_ifaces.sv
// Valid/ready channel interfaces for events, results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface hsls_in_if;
    logic valid;
    logic ready;
    logic audio_packet_ready;

    modport source (output valid, output audio_packet_ready, input ready);
    modport sink   (input valid, input audio_packet_ready, output ready);
endinterface : hsls_in_if

interface hsls_out_if;
    logic        valid;
    logic        ready;
    logic        finished_channel;
    logic [3:0]  list_code;
    logic        build_buffer;
    logic [11:0] line_number;
    logic [10:0] visible_line;
    logic        pixel_request;
    logic        frame_start;
    logic        audio_taken;
    logic        scheduler_tick;
    logic [31:0] frames_sent;

    modport source (
        output valid, input ready,
        output finished_channel, output list_code, output build_buffer,
        output line_number, output visible_line, output pixel_request,
        output frame_start, output audio_taken, output scheduler_tick,
        output frames_sent
    );
    modport sink (
        input valid, output ready,
        input finished_channel, input list_code, input build_buffer,
        input line_number, input visible_line, input pixel_request,
        input frame_start, input audio_taken, input scheduler_tick,
        input frames_sent
    );
endinterface : hsls_out_if

interface hsls_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [10:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : hsls_cfg_if

`default_nettype wire

### rtl/hsls_line_decode.sv
// Scanline region decode, list selection and counter advance for one event.
`timescale 1ns / 1ps
`default_nettype none

module hsls_line_decode
    import hsls_pkg::*;
#(
    parameter int  LINE_BITS        = LINE_BITS_DEF,
    parameter int  ACR_PERIOD_LINES = ACR_PERIOD_DEF,
    localparam int PH_W             = (ACR_PERIOD_LINES > 1) ? $clog2(ACR_PERIOD_LINES) : 1
) (
    input  var t_timing              i_timing,
    input  wire [LINE_BITS-1:0]      i_scan,
    input  wire [PH_W-1:0]           i_phase,
    input  wire                      i_posted,
    input  wire                      i_pong,
    input  wire                      i_audio,
    output t_decision                o_dec,
    output logic [LINE_BITS-1:0]     o_scan_next,
    output logic [PH_W-1:0]          o_phase_next,
    output logic                     o_posted_next
);

    localparam int CW   = (LINE_BITS > LINE_NUM_W) ? LINE_BITS : LINE_NUM_W;

    logic [7:0]          sync_start;
    logic [8:0]          bp_start;
    logic [9:0]          act_start;
    logic [11:0]         total;
    logic [CW-1:0]       s_ext;
    logic                hdmi;
    logic                in_front;
    logic                in_vsync;
    logic                in_back;
    logic                in_active;
    logic                acr;
    logic                fstart;
    logic [LINE_BITS-1:0] nxt;
    logic [LINE_BITS-1:0] adv;

    // Region boundaries from the timing registers
    assign sync_start = i_timing.vert_front_porch;
    assign bp_start   = {1'b0, sync_start} + {1'b0, i_timing.vert_sync_lines};
    assign act_start  = {1'b0, bp_start} + {2'b00, i_timing.vert_back_porch};
    assign total      = {2'b00, act_start} + {1'b0, i_timing.vert_active_lines};

    assign s_ext     = CW'(i_scan);
    assign hdmi      = !i_timing.dvi_only;
    assign in_front  = s_ext < CW'(sync_start);
    assign in_vsync  = !in_front && (s_ext < CW'(bp_start));
    assign in_back   = (s_ext >= CW'(bp_start)) && (s_ext < CW'(act_start));
    assign in_active = !in_front && !in_vsync && !in_back;
    assign acr       = in_back && (i_phase == '0);
    assign fstart    = in_vsync && (s_ext == CW'(sync_start));

    // Select the list and side flags
    always_comb begin
        o_dec                = '0;
        o_dec.list_code      = LC_DVI_BLANK;
        o_dec.scheduler_tick = hdmi && !i_posted;
        o_dec.frame_start    = fstart;
        o_posted_next        = i_posted;
        if (in_active) begin
            o_dec.visible_line = VIS_W'(s_ext - CW'(act_start));
        end
        if (in_vsync) begin
            if (!hdmi) begin
                o_dec.list_code = LC_DVI_VSYNC;
            end else if (fstart) begin
                o_dec.list_code = LC_ACR_VSYNC;
            end else begin
                o_dec.list_code = LC_INFO_VSYNC;
            end
        end else if (in_active && !i_posted) begin
            o_dec.pixel_request = 1'b1;
            o_posted_next       = 1'b1;
            if (!hdmi) begin
                o_dec.list_code = LC_DVI_ACTIVE;
            end else if (i_audio) begin
                o_dec.list_code    = LC_ACTIVE_AUDIO;
                o_dec.audio_taken  = 1'b1;
                o_dec.build_buffer = i_pong;
            end else begin
                o_dec.list_code = LC_ACTIVE_NULL;
            end
        end else if (in_active) begin
            o_dec.list_code = LC_PIXELS;
            o_posted_next   = 1'b0;
        end else begin
            if (!hdmi) begin
                o_dec.list_code = LC_DVI_BLANK;
            end else if (acr) begin
                o_dec.list_code = LC_ACR_BLANK;
            end else if (i_scan == '0) begin
                o_dec.list_code = LC_AVI;
            end else if (i_audio) begin
                o_dec.list_code    = LC_BLANK_AUDIO;
                o_dec.audio_taken  = 1'b1;
                o_dec.build_buffer = i_pong;
            end else begin
                o_dec.list_code = LC_BLANK_NULL;
            end
        end
    end

    // Advance the counter and its ACR phase unless a pixel list is posted; wrap to line 0 at the frame total
    assign nxt = i_scan + LINE_BITS'(1);
    assign adv = (CW'(nxt) >= CW'(total)) ? '0 : nxt;

    always_comb begin
        o_scan_next  = i_scan;
        o_phase_next = i_phase;
        if (!o_posted_next) begin
            o_scan_next = adv;
            if (adv == '0 || i_phase == PH_W'(ACR_PERIOD_LINES - 1)) begin
                o_phase_next = '0;
            end else begin
                o_phase_next = i_phase + PH_W'(1);
            end
        end
    end

endmodule : hsls_line_decode

`default_nettype wire

### rtl/hdmi_scanline_list_sequencer.sv
// Path: an accepted event passes through the input register, then the result register, and is
// held longer only while the sink stalls.
// Throughput: one event per cycle; the input register takes a new event while a result waits.
// Unless the sink stalls, the rate is set by the combinational line decode between the registers.
// Reset (synchronous, active low): scanline 2, ping channel next, no list posted,
// frame count 0, timing registers 0/10/2/33/480, both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module hdmi_scanline_list_sequencer
    import hsls_pkg::*;
#(
    parameter int LINE_BITS        = LINE_BITS_DEF,
    parameter int ACR_PERIOD_LINES = ACR_PERIOD_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    hsls_cfg_if.sink    i_cfg,
    hsls_in_if.sink     i_in,
    hsls_out_if.source  o_out
);

    localparam int PH_W   = (ACR_PERIOD_LINES > 1) ? $clog2(ACR_PERIOD_LINES) : 1;
    localparam int PH_RST = SCAN_RST % ACR_PERIOD_LINES;

    t_timing              r_cfg;
    logic                 r_in_valid;
    logic                 r_in_audio;
    logic                 r_out_valid;
    logic [LINE_BITS-1:0] r_scan;
    logic [PH_W-1:0]      r_phase;
    logic                 r_posted;
    logic                 r_pong;
    logic [FRAME_W-1:0]   r_frames;

    logic [LINE_BITS-1:0] n_scan;
    logic [PH_W-1:0]      n_phase;
    logic                 n_posted;
    logic [FRAME_W-1:0]   n_frames;
    t_decision            dec;
    logic                 move;

    // Handshakes
    assign move        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || move;
    assign i_cfg.ready = 1'b1;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dvi_only          <= RST_DVI_ONLY;
            r_cfg.vert_front_porch  <= RST_FRONT_PORCH;
            r_cfg.vert_sync_lines   <= RST_SYNC_LINES;
            r_cfg.vert_back_porch   <= RST_BACK_PORCH;
            r_cfg.vert_active_lines <= RST_ACTIVE_LINES;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DVI_ONLY:     r_cfg.dvi_only          <= i_cfg.data[0];
                CFG_FRONT_PORCH:  r_cfg.vert_front_porch  <= i_cfg.data[7:0];
                CFG_SYNC_LINES:   r_cfg.vert_sync_lines   <= i_cfg.data[7:0];
                CFG_BACK_PORCH:   r_cfg.vert_back_porch   <= i_cfg.data[7:0];
                CFG_ACTIVE_LINES: r_cfg.vert_active_lines <= i_cfg.data[10:0];
                default: ;
            endcase
        end
    end

    // Hold the incoming event until it moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_audio <= i_in.audio_packet_ready;
        end
    end

    // Decode the held event against the current sequencer state
    hsls_line_decode #(
        .LINE_BITS        (LINE_BITS),
        .ACR_PERIOD_LINES (ACR_PERIOD_LINES)
    ) u_decode (
        .i_timing      (r_cfg),
        .i_scan        (r_scan),
        .i_phase       (r_phase),
        .i_posted      (r_posted),
        .i_pong        (r_pong),
        .i_audio       (r_in_audio),
        .o_dec         (dec),
        .o_scan_next   (n_scan),
        .o_phase_next  (n_phase),
        .o_posted_next (n_posted)
    );

    assign n_frames = r_frames + FRAME_W'(dec.frame_start);

    // Advance the sequencer state on each transfer into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan   <= LINE_BITS'(SCAN_RST);
            r_phase  <= PH_W'(PH_RST);
            r_posted <= 1'b0;
            r_pong   <= 1'b0;
            r_frames <= '0;
        end else if (move) begin
            r_scan   <= n_scan;
            r_phase  <= n_phase;
            r_posted <= n_posted;
            r_pong   <= !r_pong;
            r_frames <= n_frames;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            o_out.finished_channel <= r_pong;
            o_out.list_code        <= dec.list_code;
            o_out.build_buffer     <= dec.build_buffer;
            o_out.line_number      <= LINE_NUM_W'(r_scan);
            o_out.visible_line     <= dec.visible_line;
            o_out.pixel_request    <= dec.pixel_request;
            o_out.frame_start      <= dec.frame_start;
            o_out.audio_taken      <= dec.audio_taken;
            o_out.scheduler_tick   <= dec.scheduler_tick;
            o_out.frames_sent      <= n_frames;
        end
    end

    assign o_out.valid = r_out_valid;

    // Checks
    a_pong_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_pong != $past(r_pong)))
        else $error("channel selector did not toggle on a transfer");

    a_scan_holds_on_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_posted) |=> (r_scan == $past(r_scan)))
        else $error("scanline advanced after an active line head");

    a_frames_follow_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_frames == $past(r_frames) + FRAME_W'($past(dec.frame_start))))
        else $error("frame count moved without a frame start");

    a_taken_has_audio_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.audio_taken) |->
            (o_out.list_code == LC_ACTIVE_AUDIO || o_out.list_code == LC_BLANK_AUDIO))
        else $error("audio taken on a list without audio");

    a_held_event_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !move) |=> r_in_valid)
        else $error("held event dropped before transfer");

endmodule : hdmi_scanline_list_sequencer

`default_nettype wire
